>>> hdl/wle_pkg.sv
// Shared types, codes and float constants for the wirelength exponential-terms block.
package wle_pkg;

    // Number of squarings in the exponential approximation
    localparam int SQUARINGS = 16;
    localparam int SQ_W      = $clog2(SQUARINGS);

    // Float constants (IEEE single bits)
    localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO  = 32'h0000_0000;
    localparam logic [31:0] FP_SCALE = 32'h3780_0000;   // 2^-16
    localparam logic [31:0] FP_QNAN  = 32'hFFC0_0000;
    localparam logic [30:0] MAG_30   = 31'h41F0_0000;   // |-30.0|

    // Configuration register indexes
    localparam logic [1:0] CFG_SMOOTH = 2'd0;
    localparam logic [1:0] CFG_PINS   = 2'd1;

    localparam logic [31:0] SMOOTH_RST = 32'h3F80_0000;
    localparam logic [9:0]  PINS_RST   = 10'd2;

    // Float unit operations
    typedef enum logic [1:0] {
        F_ADD,
        F_SUB,
        F_MUL,
        F_MOV
    } fop_t;

    // Datapath operand and destination registers
    typedef enum logic [3:0] {
        SRC_X,
        SRC_XMAX,
        SRC_XMIN,
        SRC_IG,
        SRC_BP,
        SRC_CP,
        SRC_BM,
        SRC_CM,
        SRC_T,
        SRC_AP,
        SRC_AM,
        SRC_P,
        SRC_ONE,
        SRC_ZERO,
        SRC_SCALE
    } src_t;

    // Which pin a result word describes
    typedef enum logic [1:0] {
        EM_MAXPIN,
        EM_MINPIN,
        EM_PIN
    } emit_t;

    // Controller to datapath commands
    typedef struct packed {
        fop_t  fop;
        src_t  a;
        src_t  b;
        src_t  dst;
        logic  wb;
        logic  chk;
        logic  clamp;
        logic  ld_x;
        logic  ld_max;
        logic  ld_min;
        logic  emit;
        emit_t ekind;
        logic  elast;
    } wle_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } wle_stat_t;

endpackage

>>> hdl/wle_fpu.sv
// Three-stage IEEE single add/subtract/multiply/move unit, round to nearest even.
module wle_fpu import wle_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  fop_t        fop,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] result
);

    // ---------------- stage 1: specials, mantissa product or aligned sum
    logic        sa, sb, sbe;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  eaf, ebf;
    logic        a_big;
    logic [7:0]  el, es;
    logic [23:0] ml, ms;
    logic        sl;
    logic [7:0]  dexp;
    logic [46:0] ms_ext, ms_sh, al;
    logic        lost;
    logic [47:0] sum;

    logic        c1_special;
    logic [31:0] c1_bits;
    logic        c1_sign;
    logic signed [10:0] c1_ex;
    logic [47:0] c1_mt;

    always_comb
    begin
        sa = op_a[31]; ea = op_a[30:23]; fa = op_a[22:0];
        sb = op_b[31]; eb = op_b[30:23]; fb = op_b[22:0];
        sbe    = sb ^ (fop == F_SUB);
        a_nan  = (ea == 8'hFF) && (fa != 23'd0);
        b_nan  = (eb == 8'hFF) && (fb != 23'd0);
        a_inf  = (ea == 8'hFF) && (fa == 23'd0);
        b_inf  = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma  = {ea != 8'd0, fa};
        mb  = {eb != 8'd0, fb};
        eaf = (ea == 8'd0) ? 8'd1 : ea;
        ebf = (eb == 8'd0) ? 8'd1 : eb;

        // alignment for add: larger magnitude first
        a_big  = (op_a[30:0] >= op_b[30:0]);
        el     = a_big ? eaf : ebf;
        es     = a_big ? ebf : eaf;
        ml     = a_big ? ma : mb;
        ms     = a_big ? mb : ma;
        sl     = a_big ? sa : sbe;
        dexp   = el - es;
        ms_ext = {ms, 23'd0};
        if (dexp >= 8'd47)
        begin
            ms_sh = 47'd0;
            lost  = (ms != 24'd0);
        end
        else
        begin
            ms_sh = ms_ext >> dexp;
            lost  = ((ms_sh << dexp) != ms_ext);
        end
        al = {ms_sh[46:1], ms_sh[0] | lost};
        if (sa == sbe)
            sum = {1'b0, ml, 23'd0} + {1'b0, al};
        else
            sum = {1'b0, ml, 23'd0} - {1'b0, al};

        c1_special = 1'b0;
        c1_bits    = FP_ZERO;
        c1_sign    = 1'b0;
        c1_ex      = 11'sd0;
        c1_mt      = 48'd0;
        case (fop)
            F_MOV:
            begin
                c1_special = 1'b1;
                c1_bits    = op_a;
            end
            F_MUL:
            begin
                c1_sign = sa ^ sb;
                if (a_nan)
                begin
                    c1_special = 1'b1;
                    c1_bits    = op_a | 32'h0040_0000;
                end
                else if (b_nan)
                begin
                    c1_special = 1'b1;
                    c1_bits    = op_b | 32'h0040_0000;
                end
                else if ((a_inf && b_zero) || (b_inf && a_zero))
                begin
                    c1_special = 1'b1;
                    c1_bits    = FP_QNAN;
                end
                else if (a_inf || b_inf)
                begin
                    c1_special = 1'b1;
                    c1_bits    = {sa ^ sb, 8'hFF, 23'd0};
                end
                else if (a_zero || b_zero)
                begin
                    c1_special = 1'b1;
                    c1_bits    = {sa ^ sb, 31'd0};
                end
                else
                begin
                    c1_ex = $signed({3'b000, eaf}) + $signed({3'b000, ebf}) - 11'sd127;
                    c1_mt = ma * mb;
                end
            end
            default:
            begin
                c1_sign = sl;
                if (a_nan)
                begin
                    c1_special = 1'b1;
                    c1_bits    = op_a | 32'h0040_0000;
                end
                else if (b_nan)
                begin
                    c1_special = 1'b1;
                    c1_bits    = op_b | 32'h0040_0000;
                end
                else if (a_inf && b_inf && (sa != sbe))
                begin
                    c1_special = 1'b1;
                    c1_bits    = FP_QNAN;
                end
                else if (a_inf)
                begin
                    c1_special = 1'b1;
                    c1_bits    = op_a;
                end
                else if (b_inf)
                begin
                    c1_special = 1'b1;
                    c1_bits    = {sbe, 8'hFF, 23'd0};
                end
                else if (a_zero && b_zero)
                begin
                    c1_special = 1'b1;
                    c1_bits    = {sa & sbe, 31'd0};
                end
                else if (sum == 48'd0)
                begin
                    c1_special = 1'b1;
                    c1_bits    = FP_ZERO;
                end
                else
                begin
                    c1_ex = $signed({3'b000, el});
                    c1_mt = sum;
                end
            end
        endcase
    end

    logic        s1_special_reg, s2_special_reg;
    logic [31:0] s1_bits_reg, s2_bits_reg;
    logic        s1_sign_reg, s2_sign_reg;
    logic signed [10:0] s1_ex_reg, s2_ex_reg;
    logic [47:0] s1_mt_reg, s2_mt_reg;
    logic signed [7:0]  s2_sh_reg;

    // ---------------- stage 2: leading one and shift amount
    logic [5:0]  lead;
    logic signed [10:0] lm, rm, shw;
    logic signed [7:0]  sh_next;

    always_comb
    begin
        lead = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (s1_mt_reg[i])
                lead = 6'(i);
        end
        lm  = $signed({5'b00000, lead}) - 11'sd23;
        rm  = 11'sd24 - s1_ex_reg;
        shw = (lm > rm) ? lm : rm;
        if (shw > 11'sd50)
            shw = 11'sd50;
        sh_next = shw[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_special_reg <= 1'b1;
            s2_special_reg <= 1'b1;
        end
        else
        begin
            s1_special_reg <= c1_special;
            s2_special_reg <= s1_special_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bits_reg <= c1_bits;
        s1_sign_reg <= c1_sign;
        s1_ex_reg   <= c1_ex;
        s1_mt_reg   <= c1_mt;
        s2_bits_reg <= s1_bits_reg;
        s2_sign_reg <= s1_sign_reg;
        s2_ex_reg   <= s1_ex_reg;
        s2_mt_reg   <= s1_mt_reg;
        s2_sh_reg   <= sh_next;
    end

    // ---------------- stage 3: shift, round, pack
    logic [4:0]  lsh;
    logic [5:0]  rsh;
    logic [97:0] wide;
    logic [23:0] q;
    logic        grd, stk, inc;
    logic [24:0] r;
    logic signed [11:0] biased, expo;
    logic [22:0] frac;

    always_comb
    begin
        lsh  = 5'(-s2_sh_reg);
        rsh  = s2_sh_reg[5:0];
        wide = {s2_mt_reg, 50'd0} >> rsh;
        if (s2_sh_reg < 8'sd0)
        begin
            q   = 24'(s2_mt_reg << lsh);
            grd = 1'b0;
            stk = 1'b0;
        end
        else
        begin
            q   = wide[73:50];
            grd = wide[49];
            stk = |wide[48:0];
        end
        inc    = grd & (stk | q[0]);
        r      = {1'b0, q} + {24'd0, inc};
        biased = {s2_ex_reg[10], s2_ex_reg} + {{4{s2_sh_reg[7]}}, s2_sh_reg} - 12'sd23;
        if (r[24])
        begin
            expo = biased + 12'sd1;
            frac = 23'd0;
        end
        else if (r[23])
        begin
            expo = biased;
            frac = r[22:0];
        end
        else
        begin
            expo = 12'sd0;
            frac = r[22:0];
        end

        if (s2_special_reg)
            result = s2_bits_reg;
        else if (expo >= 12'sd255)
            result = {s2_sign_reg, 8'hFF, 23'd0};
        else
            result = {s2_sign_reg, expo[7:0], frac};
    end

endmodule

>>> hdl/wle_datapath.sv
// Datapath: pin and accumulator registers, shared float unit, result word register.
module wle_datapath import wle_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  wle_cmd_t    cmd,
    output wle_stat_t   stat,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [31:0] coord,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] x_value,
    output logic [31:0] a_plus,
    output logic [31:0] a_minus,
    output logic [31:0] sum_b_plus,
    output logic [31:0] sum_c_plus,
    output logic [31:0] sum_b_minus,
    output logic [31:0] sum_c_minus,
    output logic        net_last
);

    logic [31:0] ig_reg, x_reg, max_reg, min_reg;
    logic [31:0] bp_reg, cp_reg, bm_reg, cm_reg;
    logic [31:0] t_reg, ap_reg, am_reg, p_reg;
    logic        below_reg;
    logic        out_valid_reg;
    logic [31:0] ox_reg, oap_reg, oam_reg, obp_reg, ocp_reg, obm_reg, ocm_reg;
    logic        olast_reg;

    logic [31:0] opa, opb, fres, wval;
    logic        is_below;

    function automatic logic [31:0] pick(
        input src_t        s,
        input logic [31:0] x, mx, mn, ig, bp, cp, bm, cm, t, ap, am, p
    );
        case (s)
            SRC_X:     pick = x;
            SRC_XMAX:  pick = mx;
            SRC_XMIN:  pick = mn;
            SRC_IG:    pick = ig;
            SRC_BP:    pick = bp;
            SRC_CP:    pick = cp;
            SRC_BM:    pick = bm;
            SRC_CM:    pick = cm;
            SRC_T:     pick = t;
            SRC_AP:    pick = ap;
            SRC_AM:    pick = am;
            SRC_P:     pick = p;
            SRC_ONE:   pick = FP_ONE;
            SRC_SCALE: pick = FP_SCALE;
            default:   pick = FP_ZERO;
        endcase
    endfunction

    // operand select
    assign opa = pick(cmd.a, x_reg, max_reg, min_reg, ig_reg, bp_reg, cp_reg, bm_reg,
                      cm_reg, t_reg, ap_reg, am_reg, p_reg);
    assign opb = pick(cmd.b, x_reg, max_reg, min_reg, ig_reg, bp_reg, cp_reg, bm_reg,
                      cm_reg, t_reg, ap_reg, am_reg, p_reg);

    wle_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .fop    (cmd.fop),
        .op_a   (opa),
        .op_b   (opb),
        .result (fres)
    );

    // scaled exponent below -30: negative, not NaN, magnitude above 30
    assign is_below = fres[31] && !((fres[30:23] == 8'hFF) && (fres[22:0] != 23'd0))
                      && (fres[30:0] > MAG_30);
    assign wval     = (cmd.clamp && below_reg) ? FP_ZERO : fres;

    // working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ig_reg    <= SMOOTH_RST;
            x_reg     <= FP_ZERO;
            max_reg   <= FP_ZERO;
            min_reg   <= FP_ZERO;
            bp_reg    <= FP_ZERO;
            cp_reg    <= FP_ZERO;
            bm_reg    <= FP_ZERO;
            cm_reg    <= FP_ZERO;
            t_reg     <= FP_ZERO;
            ap_reg    <= FP_ZERO;
            am_reg    <= FP_ZERO;
            p_reg     <= FP_ZERO;
            below_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_SMOOTH))
                ig_reg <= cfg_data;
            if (cmd.ld_x)
                x_reg <= coord;
            if (cmd.ld_max)
                max_reg <= coord;
            if (cmd.ld_min)
                min_reg <= coord;
            if (cmd.wb && cmd.chk)
                below_reg <= is_below;
            if (cmd.wb)
            begin
                case (cmd.dst)
                    SRC_BP:  bp_reg <= wval;
                    SRC_CP:  cp_reg <= wval;
                    SRC_BM:  bm_reg <= wval;
                    SRC_CM:  cm_reg <= wval;
                    SRC_T:   t_reg  <= wval;
                    SRC_AP:  ap_reg <= wval;
                    SRC_AM:  am_reg <= wval;
                    SRC_P:   p_reg  <= wval;
                    default: ;
                endcase
            end
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.ekind)
                EM_MAXPIN:
                begin
                    ox_reg  <= max_reg;
                    oap_reg <= FP_ONE;
                    oam_reg <= ap_reg;
                end
                EM_MINPIN:
                begin
                    ox_reg  <= x_reg;
                    oap_reg <= ap_reg;
                    oam_reg <= FP_ONE;
                end
                default:
                begin
                    ox_reg  <= x_reg;
                    oap_reg <= ap_reg;
                    oam_reg <= am_reg;
                end
            endcase
            obp_reg   <= cmd.elast ? bp_reg : FP_ZERO;
            ocp_reg   <= cmd.elast ? cp_reg : FP_ZERO;
            obm_reg   <= cmd.elast ? bm_reg : FP_ZERO;
            ocm_reg   <= cmd.elast ? cm_reg : FP_ZERO;
            olast_reg <= cmd.elast;
        end
    end

    assign stat.out_free = !out_valid_reg || !result_stall;
    assign result_valid  = out_valid_reg;
    assign x_value       = ox_reg;
    assign a_plus        = oap_reg;
    assign a_minus       = oam_reg;
    assign sum_b_plus    = obp_reg;
    assign sum_c_plus    = ocp_reg;
    assign sum_b_minus   = obm_reg;
    assign sum_c_minus   = ocm_reg;
    assign net_last      = olast_reg;

endmodule

>>> hdl/wle_ctrl.sv
// Controller: microcode sequencer for the float op program, pin position and net size.
module wle_ctrl import wle_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  wle_stat_t   stat,
    output wle_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MID,
        S_WB
    } state_t;

    typedef enum logic {
        UK_ALU,
        UK_EMIT
    } ukind_t;

    typedef struct packed {
        ukind_t kind;
        fop_t   fop;
        src_t   a;
        src_t   b;
        src_t   dst;
        logic   chk;
        logic   clamp;
        logic   rep;
        emit_t  ekind;
        logic   fin;
    } uop_t;

    localparam logic [5:0] PC_GEN  = 6'd0;
    localparam logic [5:0] PC_PIN1 = 6'd19;

    function automatic uop_t alu(input fop_t f, input src_t a, input src_t b, input src_t d);
        uop_t u;
        u       = '0;
        u.kind  = UK_ALU;
        u.fop   = f;
        u.a     = a;
        u.b     = b;
        u.dst   = d;
        u.ekind = EM_PIN;
        return u;
    endfunction

    function automatic uop_t emit_op(input emit_t k, input logic fin);
        uop_t u;
        u       = '0;
        u.kind  = UK_EMIT;
        u.ekind = k;
        u.fin   = fin;
        return u;
    endfunction

    // program: exponential of a difference, then the two sums for that sign
    function automatic uop_t uop(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = alu(F_SUB, SRC_X, SRC_XMAX, SRC_T);
            6'd1:
            begin
                u = alu(F_MUL, SRC_IG, SRC_T, SRC_T);
                u.chk = 1'b1;
            end
            6'd2:  u = alu(F_MUL, SRC_T, SRC_SCALE, SRC_T);
            6'd3:  u = alu(F_ADD, SRC_T, SRC_ONE, SRC_T);
            6'd4:
            begin
                u = alu(F_MUL, SRC_T, SRC_T, SRC_T);
                u.rep = 1'b1;
            end
            6'd5:
            begin
                u = alu(F_MOV, SRC_T, SRC_ZERO, SRC_AP);
                u.clamp = 1'b1;
            end
            6'd6:  u = alu(F_ADD, SRC_BP, SRC_AP, SRC_BP);
            6'd7:  u = alu(F_MUL, SRC_X, SRC_AP, SRC_P);
            6'd8:  u = alu(F_ADD, SRC_CP, SRC_P, SRC_CP);
            6'd9:  u = alu(F_SUB, SRC_XMIN, SRC_X, SRC_T);
            6'd10:
            begin
                u = alu(F_MUL, SRC_IG, SRC_T, SRC_T);
                u.chk = 1'b1;
            end
            6'd11: u = alu(F_MUL, SRC_T, SRC_SCALE, SRC_T);
            6'd12: u = alu(F_ADD, SRC_T, SRC_ONE, SRC_T);
            6'd13:
            begin
                u = alu(F_MUL, SRC_T, SRC_T, SRC_T);
                u.rep = 1'b1;
            end
            6'd14:
            begin
                u = alu(F_MOV, SRC_T, SRC_ZERO, SRC_AM);
                u.clamp = 1'b1;
            end
            6'd15: u = alu(F_ADD, SRC_BM, SRC_AM, SRC_BM);
            6'd16: u = alu(F_MUL, SRC_X, SRC_AM, SRC_P);
            6'd17: u = alu(F_ADD, SRC_CM, SRC_P, SRC_CM);
            6'd18: u = emit_op(EM_PIN, 1'b1);
            // second pin of a net: both max and min pins are reported
            6'd19: u = alu(F_SUB, SRC_X, SRC_XMAX, SRC_T);
            6'd20:
            begin
                u = alu(F_MUL, SRC_IG, SRC_T, SRC_T);
                u.chk = 1'b1;
            end
            6'd21: u = alu(F_MUL, SRC_T, SRC_SCALE, SRC_T);
            6'd22: u = alu(F_ADD, SRC_T, SRC_ONE, SRC_T);
            6'd23:
            begin
                u = alu(F_MUL, SRC_T, SRC_T, SRC_T);
                u.rep = 1'b1;
            end
            6'd24:
            begin
                u = alu(F_MOV, SRC_T, SRC_ZERO, SRC_AP);
                u.clamp = 1'b1;
            end
            6'd25: u = alu(F_MOV, SRC_ONE, SRC_ZERO, SRC_BP);
            6'd26: u = alu(F_MOV, SRC_XMAX, SRC_ZERO, SRC_CP);
            6'd27: u = alu(F_MOV, SRC_AP, SRC_ZERO, SRC_BM);
            6'd28: u = alu(F_MUL, SRC_XMAX, SRC_AP, SRC_P);
            6'd29: u = alu(F_ADD, SRC_ZERO, SRC_P, SRC_CM);
            6'd30: u = emit_op(EM_MAXPIN, 1'b0);
            6'd31: u = alu(F_ADD, SRC_BP, SRC_AP, SRC_BP);
            6'd32: u = alu(F_MUL, SRC_X, SRC_AP, SRC_P);
            6'd33: u = alu(F_ADD, SRC_CP, SRC_P, SRC_CP);
            6'd34: u = alu(F_ADD, SRC_BM, SRC_ONE, SRC_BM);
            6'd35: u = alu(F_MUL, SRC_X, SRC_ONE, SRC_P);
            6'd36: u = alu(F_ADD, SRC_CM, SRC_P, SRC_CM);
            6'd37: u = emit_op(EM_MINPIN, 1'b1);
            default: u = emit_op(EM_PIN, 1'b1);
        endcase
        return u;
    endfunction

    state_t          state_reg, state_next;
    logic [5:0]      pc_reg, pc_next;
    logic [SQ_W-1:0] rep_reg, rep_next;
    logic [9:0]      pos_reg, pos_next;
    logic [9:0]      ppn_reg, ppn_next;
    logic [9:0]      size;
    logic [10:0]     pos_inc;
    logic            last;
    uop_t            u;

    always_comb
    begin
        u       = uop(pc_reg);
        size    = (ppn_reg < 10'd2) ? 10'd2 : ppn_reg;
        pos_inc = {1'b0, pos_reg} + 11'd1;
        case (u.ekind)
            EM_MAXPIN: last = 1'b0;
            EM_MINPIN: last = (size <= 10'd2);
            default:   last = (pos_inc >= {1'b0, size});
        endcase

        state_next = state_reg;
        pc_next    = pc_reg;
        rep_next   = rep_reg;
        pos_next   = pos_reg;
        ppn_next   = ppn_reg;
        if (cfg_we && (cfg_index == CFG_PINS))
            ppn_next = cfg_data[9:0];

        cmd        = '0;
        cmd.fop    = u.fop;
        cmd.a      = u.a;
        cmd.b      = u.b;
        cmd.dst    = u.dst;
        cmd.ekind  = u.ekind;
        cmd.elast  = last;
        item_stall = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.ld_x = 1'b1;
                    if (pos_reg == 10'd0)
                    begin
                        cmd.ld_max = 1'b1;
                        pos_next   = 10'd1;
                    end
                    else if (pos_reg == 10'd1)
                    begin
                        cmd.ld_min = 1'b1;
                        pc_next    = PC_PIN1;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        pc_next    = PC_GEN;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (u.kind == UK_ALU)
                    state_next = S_MID;
                else if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (u.fin)
                    begin
                        state_next = S_IDLE;
                        if (last)
                            pos_next = 10'd0;
                        else if (u.ekind == EM_MINPIN)
                            pos_next = 10'd2;
                        else
                            pos_next = pos_inc[9:0];
                    end
                    else
                        pc_next = pc_reg + 6'd1;
                end
            end
            S_MID:
                state_next = S_WB;
            S_WB:
            begin
                cmd.wb     = 1'b1;
                cmd.chk    = u.chk;
                cmd.clamp  = u.clamp;
                state_next = S_EXEC;
                if (u.rep && (rep_reg != SQ_W'(SQUARINGS - 1)))
                    rep_next = rep_reg + 1'b1;
                else
                begin
                    rep_next = '0;
                    pc_next  = pc_reg + 6'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= PC_GEN;
            rep_reg   <= '0;
            pos_reg   <= 10'd0;
            ppn_reg   <= PINS_RST;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            rep_reg   <= rep_next;
            pos_reg   <= pos_next;
            ppn_reg   <= ppn_next;
        end
    end

endmodule

>>> hdl/wa_wirelength_exp_terms_core.sv
// Weighted-average wirelength exponential terms: top level.
//
// Input channel (item_valid / item_stall / coord): one float pin coordinate
// per word; per net the max pin, then the min pin, then the rest.
// Output channel (result_valid / result_stall): one word per pin with x,
// a_plus and a_minus; the net's last word carries net_last and the four sums.
// Configuration: cfg_we writes the 1/gamma scale (index 0) or pins_per_net (index 1).
// Operation: the first pin of a net is taken and makes no word. Every later
// pin runs a microcoded program on one shared three-stage float unit, one
// float op at a time: a plain pin is 48 ops (two exponentials of 21 ops
// each); the second pin is 32 ops plus two words. item_stall is high while
// a pin is in work. The last word of a pin sits in the output register while
// the next pin is taken; a stalled receiver holds up the program only when it
// is about to write a new word.
// Reset clears the pin position, the sums and restores the register defaults.
module wa_wirelength_exp_terms_core import wle_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] coord,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] x_value,
    output logic [31:0] a_plus,
    output logic [31:0] a_minus,
    output logic [31:0] sum_b_plus,
    output logic [31:0] sum_c_plus,
    output logic [31:0] sum_b_minus,
    output logic [31:0] sum_c_minus,
    output logic        net_last
);

    wle_cmd_t  cmd;
    wle_stat_t stat;

    wle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .cmd        (cmd)
    );

    wle_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .coord        (coord),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .x_value      (x_value),
        .a_plus       (a_plus),
        .a_minus      (a_minus),
        .sum_b_plus   (sum_b_plus),
        .sum_c_plus   (sum_c_plus),
        .sum_b_minus  (sum_b_minus),
        .sum_c_minus  (sum_c_minus),
        .net_last     (net_last)
    );

endmodule

>>> hdl/wle_checker.sv
// Port-level checker for the exponential-terms block, bound to the top level.
module wle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] x_value,
    input logic [31:0] sum_b_plus,
    input logic [31:0] sum_c_plus,
    input logic [31:0] sum_b_minus,
    input logic [31:0] sum_c_minus,
    input logic        net_last
);

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(x_value))
        else $error("result word changed under stall");

    // sums are zero except on the last word of a net
    a_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !net_last |->
            sum_b_plus == 32'd0 && sum_c_plus == 32'd0 &&
            sum_b_minus == 32'd0 && sum_c_minus == 32'd0)
        else $error("sums nonzero on a word that is not last");

    // the sums of exponentials include a 1.0 term, never zero
    a_b_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && net_last |-> sum_b_plus != 32'd0 && sum_b_minus != 32'd0)
        else $error("b sum is zero on last word");

    // a new word is only loaded while a pin is in work
    a_word_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("unexpected result word");

endmodule

bind wa_wirelength_exp_terms_core wle_checker u_wle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .x_value      (x_value),
    .sum_b_plus   (sum_b_plus),
    .sum_c_plus   (sum_c_plus),
    .sum_b_minus  (sum_b_minus),
    .sum_c_minus  (sum_c_minus),
    .net_last     (net_last)
);

>>> tb/wa_wirelength_exp_terms_checker.sv
// Checker for the wirelength exponential-terms core: predicts result words and compares them.
module wa_wirelength_exp_terms_checker import wle_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [31:0] coord,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] x_value,
    input  logic [31:0] a_plus,
    input  logic [31:0] a_minus,
    input  logic [31:0] sum_b_plus,
    input  logic [31:0] sum_c_plus,
    input  logic [31:0] sum_b_minus,
    input  logic [31:0] sum_c_minus,
    input  logic        net_last,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result word
    typedef struct {
        logic [31:0] x;
        logic [31:0] ap;
        logic [31:0] am;
        logic [31:0] bp;
        logic [31:0] cp;
        logic [31:0] bm;
        logic [31:0] cm;
        logic        last;
    } pin_word_t;

    pin_word_t   pin_words[$];

    // Predictor copy of the registers and the net state
    logic [31:0] gamma_inv;
    logic [9:0]  net_pins;
    logic [31:0] max_x, min_x;
    logic [31:0] bp_sum, cp_sum, bm_sum, cm_sum;
    logic [9:0]  pin_idx;

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 0;
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:0] == 31'h7F80_0000;
    endfunction

    // Round value sig * 2^ex to single, nearest even
    function automatic logic [31:0] fp_round(input logic s, input logic [127:0] sig, input int ex);
        int k, be, sh;
        logic [127:0] q, rem, half;
        if (sig == 0)
            return {s, 31'd0};
        k = 127;
        while (!sig[k])
            k--;
        be = k + ex + 127;
        sh = (be >= 1) ? k - 23 : -149 - ex;
        if (sh <= 0)
            q = sig << (-sh);
        else if (sh > 120)
            q = 0;
        else
        begin
            q = sig >> sh;
            rem = sig & ((128'd1 << sh) - 1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
        end
        if (be >= 1)
        begin
            if (q[24])
            begin
                q = q >> 1;
                be++;
            end
            if (be >= 255)
                return {s, 8'hFF, 23'd0};
            return {s, be[7:0], q[22:0]};
        end
        return {s, q[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        int ea, eb;
        logic [23:0] ma, mb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b))
            return FP_QNAN;
        if (is_inf(a) || is_inf(b))
        begin
            if (a[30:0] == 0 || b[30:0] == 0)
                return FP_QNAN;
            return {s, 8'hFF, 23'd0};
        end
        ma = {a[30:23] != 0, a[22:0]};
        mb = {b[30:23] != 0, b[22:0]};
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        return fp_round(s, 128'(ma) * 128'(mb), ea + eb - 300);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi, lo;
        logic s;
        int eh, el, d;
        logic [127:0] mh, ml, sum;
        if (is_nan(a) || is_nan(b))
            return FP_QNAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31])
            return FP_QNAN;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        hi = (a[30:0] < b[30:0]) ? b : a;
        lo = (a[30:0] < b[30:0]) ? a : b;
        eh = (hi[30:23] == 0) ? 1 : int'(hi[30:23]);
        el = (lo[30:23] == 0) ? 1 : int'(lo[30:23]);
        mh = 128'({hi[30:23] != 0, hi[22:0]}) << 3;
        ml = 128'({lo[30:23] != 0, lo[22:0]}) << 3;
        d = eh - el;
        if (d >= 30)
            ml = 128'(ml != 0);
        else
            ml = (ml >> d) | 128'((ml & ((128'd1 << d) - 1)) != 0);
        sum = (hi[31] == lo[31]) ? mh + ml : mh - ml;
        s = (sum == 0) ? (a[31] & b[31]) : hi[31];
        return fp_round(s, sum, eh - 153);
    endfunction

    // (1 + t/65536) squared SQUARINGS times, zero when t < -30
    function automatic logic [31:0] exp_term(input logic [31:0] diff);
        logic [31:0] t, e;
        logic under;
        t = fp_mul(gamma_inv, diff);
        under = t[31] && !is_nan(t) && t[30:0] > MAG_30;
        e = fp_add(fp_mul(t, FP_SCALE), FP_ONE);
        for (int i = 0; i < SQUARINGS; i++)
            e = fp_mul(e, e);
        return under ? FP_ZERO : e;
    endfunction

    function automatic pin_word_t make_word(input logic [31:0] x, input logic [31:0] ap,
                                            input logic [31:0] am, input logic last);
        pin_word_t w;
        w.x = x;
        w.ap = ap;
        w.am = am;
        w.bp = last ? bp_sum : FP_ZERO;
        w.cp = last ? cp_sum : FP_ZERO;
        w.bm = last ? bm_sum : FP_ZERO;
        w.cm = last ? cm_sum : FP_ZERO;
        w.last = last;
        return w;
    endfunction

    // Advance the net state by one coordinate and queue the words it makes
    task automatic predict_pin(input logic [31:0] x);
        logic [9:0] size;
        logic [31:0] d, ap, am;
        logic last;
        size = (net_pins < 2) ? 10'd2 : net_pins;
        if (pin_idx == 0)
        begin
            max_x = x;
            pin_idx = 1;
        end
        else if (pin_idx == 1)
        begin
            d = exp_term(fp_add(x, max_x ^ 32'h8000_0000));
            min_x = x;
            bp_sum = FP_ONE;
            cp_sum = max_x;
            bm_sum = d;
            cm_sum = fp_add(FP_ZERO, fp_mul(max_x, d));
            pin_words.push_back(make_word(max_x, FP_ONE, d, 1'b0));
            bp_sum = fp_add(bp_sum, d);
            cp_sum = fp_add(cp_sum, fp_mul(x, d));
            bm_sum = fp_add(bm_sum, FP_ONE);
            cm_sum = fp_add(cm_sum, fp_mul(x, FP_ONE));
            last = (size <= 2);
            pin_words.push_back(make_word(x, d, FP_ONE, last));
            pin_idx = last ? 10'd0 : 10'd2;
        end
        else
        begin
            ap = exp_term(fp_add(x, max_x ^ 32'h8000_0000));
            bp_sum = fp_add(bp_sum, ap);
            cp_sum = fp_add(cp_sum, fp_mul(x, ap));
            am = exp_term(fp_add(min_x, x ^ 32'h8000_0000));
            bm_sum = fp_add(bm_sum, am);
            cm_sum = fp_add(cm_sum, fp_mul(x, am));
            last = ({1'b0, pin_idx} + 11'd1 >= {1'b0, size});
            pin_words.push_back(make_word(x, ap, am, last));
            pin_idx = last ? 10'd0 : pin_idx + 10'd1;
        end
    endtask

    // A NaN expectation accepts any NaN
    function automatic logic same(input logic [31:0] e, input logic [31:0] a);
        return is_nan(e) ? is_nan(a) : (e == a);
    endfunction

    task automatic check_word();
        pin_word_t w;
        logic ok;
        if (pin_words.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word x=%h last=%b", x_value, net_last);
            return;
        end
        w = pin_words.pop_front();
        ok = same(w.x, x_value) && same(w.ap, a_plus) && same(w.am, a_minus)
             && same(w.bp, sum_b_plus) && same(w.cp, sum_c_plus)
             && same(w.bm, sum_b_minus) && same(w.cm, sum_c_minus) && w.last == net_last;
        if (!ok)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp x=%h ap=%h am=%h bp=%h cp=%h bm=%h cm=%h last=%b\n%s",
                         w.x, w.ap, w.am, w.bp, w.cp, w.bm, w.cm, w.last,
                         $sformatf("         got x=%h ap=%h am=%h bp=%h cp=%h bm=%h cm=%h last=%b",
                                   x_value, a_plus, a_minus, sum_b_plus, sum_c_plus,
                                   sum_b_minus, sum_c_minus, net_last));
        end
    endtask

    initial errors = 0;

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_inv = SMOOTH_RST;
            net_pins = PINS_RST;
            max_x = 0;
            min_x = 0;
            bp_sum = 0;
            cp_sum = 0;
            bm_sum = 0;
            cm_sum = 0;
            pin_idx = 0;
            pin_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SMOOTH)
                    gamma_inv = cfg_data;
                else if (cfg_index == CFG_PINS)
                    net_pins = cfg_data[9:0];
            end
            if (result_valid && !result_stall)
                check_word();
            if (item_valid && !item_stall)
                predict_pin(coord);
        end
        pending <= pin_words.size();
    end
endmodule

>>> tb/wa_wirelength_exp_terms_core_test.sv
// Top of the wirelength exponential-terms testbench: stimulus, configuration and verdict.
module wa_wirelength_exp_terms_core_test import wle_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES = 400;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic        item_valid = 0;
    logic        item_stall;
    logic [31:0] coord = 0;
    logic        result_valid;
    logic        result_stall = 0;
    logic [31:0] x_value, a_plus, a_minus;
    logic [31:0] sum_b_plus, sum_c_plus, sum_b_minus, sum_c_minus;
    logic        net_last;
    int          errors, pending;

    // Idling controls
    logic        calm = 0;
    int          hold_left = 0;
    int          burst_left = 0;
    logic [9:0]  cur_pins = PINS_RST;

    wa_wirelength_exp_terms_core u_dut (.*);

    wa_wirelength_exp_terms_checker u_chk (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver stall: random bursts, a long hold on request, none when calm
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1;
            hold_left--;
        end
        else if (calm)
            result_stall <= 0;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 18);
            result_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_PINS)
            cur_pins = val[9:0];
    endtask

    // Present one word, sometimes after a random gap, and wait for acceptance
    task automatic send_word(input logic [31:0] w);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_valid <= 1;
        coord <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Sender stops until every expected word is back, then the block settles
    task automatic drain();
        item_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        return {1'($urandom), 8'($urandom_range(118, 133)), 23'($urandom)};
    endfunction

    // Total order key for finite floats
    function automatic logic [31:0] order_key(input logic [31:0] f);
        return f[31] ? ~f : (f | 32'h8000_0000);
    endfunction

    // One net: max, min, then the rest; sometimes noise or swapped order
    task automatic send_net(inout int sent);
        logic [31:0] pins[$];
        int sz, imax, imin;
        logic [31:0] t;
        sz = (cur_pins < 2) ? 2 : cur_pins;
        for (int i = 0; i < sz; i++)
            pins.push_back(rand_coord());
        imax = 0;
        for (int i = 1; i < sz; i++)
            if (order_key(pins[i]) > order_key(pins[imax]))
                imax = i;
        t = pins[0]; pins[0] = pins[imax]; pins[imax] = t;
        imin = 1;
        for (int i = 2; i < sz; i++)
            if (order_key(pins[i]) < order_key(pins[imin]))
                imin = i;
        t = pins[1]; pins[1] = pins[imin]; pins[imin] = t;
        if ($urandom_range(0, 19) == 0)
        begin
            t = pins[0]; pins[0] = pins[1]; pins[1] = t;
        end
        foreach (pins[i])
        begin
            send_word(($urandom_range(0, 11) == 0) ? $urandom : pins[i]);
            sent++;
        end
    endtask

    task automatic run_phase(input logic [31:0] ig, input logic [9:0] npins, input int items);
        int sent;
        sent = 0;
        cfg_write(CFG_SMOOTH, ig);
        cfg_write(CFG_PINS, {$urandom} & 32'hFFFF_FC00 | 32'(npins));
        while (sent < items)
            send_net(sent);
        drain();
    endtask

    function automatic logic [31:0] rand_gamma();
        return {1'b0, 8'($urandom_range(118, 132)), 23'($urandom)};
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        repeat (3) @(posedge clk);

        // Two-pin nets at reset defaults: zeros, signed zero, overflow, inf, NaN, subnormals
        send_word(32'h3F80_0000); send_word(32'h0000_0000);
        send_word(32'h8000_0000); send_word(32'h0000_0000);
        send_word(32'h7F7F_FFFF); send_word(32'hFF7F_FFFF);
        send_word(32'h7F80_0000); send_word(32'hFF80_0000);
        send_word(32'h7FC0_0000); send_word(32'h0000_0000);
        send_word(32'h0000_0001); send_word(32'h8000_0001);
        drain();
        // Short size treated as two; spare indexes ignored
        cfg_write(CFG_PINS, 32'd0);
        cfg_write(CFG_SPARE_A, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_B, 32'h0000_0007);
        send_word(32'hFFFF_FFFF); send_word(32'h0000_0000);
        drain();
        cfg_write(CFG_PINS, 32'd1);
        send_word(32'h4000_0000); send_word(32'h3F00_0000);
        drain();
        // Exponent below -30 gives zero
        cfg_write(CFG_PINS, 32'd3);
        send_word(32'h42C8_0000); send_word(32'h0000_0000); send_word(32'h4248_0000);
        send_word(32'h3F80_0000); send_word(32'h0000_0000); send_word(32'h3F00_0000);
        drain();
        // NaN and infinite scale
        cfg_write(CFG_SMOOTH, 32'hFFFF_FFFF);
        cfg_write(CFG_PINS, 32'd2);
        send_word(32'h3F80_0000); send_word(32'h0000_0000);
        drain();
        cfg_write(CFG_SMOOTH, 32'h7F80_0000);
        send_word(32'h3F80_0000); send_word(32'h0000_0000);
        drain();

        // Random phases
        run_phase(32'h3F80_0000, 10'd3, 200);
        hold_left = 3000;
        run_phase(rand_gamma(), 10'($urandom_range(2, 8)), 300);
        run_phase(32'h0000_0000, 10'd2, 100);
        run_phase(32'h7F7F_FFFF, 10'd4, 100);
        repeat (6)
            run_phase(rand_gamma(), 10'($urandom_range(2, 6)), 150);

        // Largest size, then shrink inside the net so it ends early
        cfg_write(CFG_PINS, 32'd1023);
        repeat (5) send_word(rand_coord());
        drain();
        cfg_write(CFG_PINS, 32'd3);
        send_word(rand_coord());
        drain();

        // Final stretch with no idling
        calm = 1;
        run_phase(rand_gamma(), 10'd5, 250);

        drain();
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> filelist.f
hdl/wle_pkg.sv
hdl/wle_fpu.sv
hdl/wle_datapath.sv
hdl/wle_ctrl.sv
hdl/wa_wirelength_exp_terms_core.sv
hdl/wle_checker.sv
tb/wa_wirelength_exp_terms_checker.sv
tb/wa_wirelength_exp_terms_core_test.sv
